FILE: hw/rtl/bfb_pkg.sv
// ----------------------------------------------------------------------------
// Boot frame builder package
// Shared constants, codes, sequencer types and the CRC-32 byte update.
// ----------------------------------------------------------------------------
package bfb_pkg;

    localparam int MAX_CHUNK = 32;
    localparam int HDR_LEN   = 10;  // chunk header, count, header CRC, data CRC
    localparam int CTRL_LEN  = 6;   // command, zero, CRC
    localparam int ADDR_W    = (MAX_CHUNK > 1) ? $clog2(MAX_CHUNK) : 1;
    localparam int CNT_W     = $clog2(MAX_CHUNK + 1);
    localparam int IDX_W     = $clog2(MAX_CHUNK + HDR_LEN);

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_STOP  = 2'd1;
    localparam logic [1:0] FUNC_CHUNK = 2'd2;

    localparam logic [1:0] REG_START_CMD = 2'd0;
    localparam logic [1:0] REG_END_CMD   = 2'd1;
    localparam logic [1:0] REG_CHUNK_CMD = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_HDR0 = 4'b0010,
        S_HDR1 = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    typedef struct packed {
        logic             go;
        logic [IDX_W-1:0] last_idx;
    } t_seq_req;

    typedef struct packed {
        logic             busy;
        logic             hdr0;
        logic             hdr1;
        logic             emit;
        logic             done;
        logic [IDX_W-1:0] idx;
    } t_seq_ctrl;

    // Reflected CRC-32 update by one byte, least significant bit first.
    function automatic logic [31:0] crc_feed(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/bfb_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module bfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: hw/rtl/bfb_crc_unit.sv
// ----------------------------------------------------------------------------
// CRC-32 update unit
// Shared byte-wide CRC step, used for payload bytes and for frame headers.
// ----------------------------------------------------------------------------
module bfb_crc_unit (
    input  logic [31:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [31:0] o_crc
);
    import bfb_pkg::*;

    assign o_crc = crc_feed(i_crc, i_byte);

endmodule

FILE: hw/rtl/bfb_seq.sv
// ----------------------------------------------------------------------------
// Frame sequencer
// Steps the header CRC through the shared unit, then counts out the beats.
// ----------------------------------------------------------------------------
module bfb_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bfb_pkg::t_seq_req  i_req,
    output bfb_pkg::t_seq_ctrl o_ctrl
);
    import bfb_pkg::*;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_last_idx, n_last_idx;
    logic             done;

    assign done = (r_state == S_EMIT) && (r_idx == r_last_idx);

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_last_idx = r_last_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.go) begin
                    n_state    = S_HDR0;
                    n_last_idx = i_req.last_idx;
                end
            end
            S_HDR0: begin
                n_state = S_HDR1;
            end
            S_HDR1: begin
                n_state = S_EMIT;
                n_idx   = '0;
            end
            S_EMIT: begin
                n_idx = r_idx + IDX_W'(1);
                if (done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_idx      <= '0;
            r_last_idx <= '0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_last_idx <= n_last_idx;
        end
    end

    assign o_ctrl.busy = (r_state != S_IDLE);
    assign o_ctrl.hdr0 = (r_state == S_HDR0);
    assign o_ctrl.hdr1 = (r_state == S_HDR1);
    assign o_ctrl.emit = (r_state == S_EMIT);
    assign o_ctrl.done = done;
    assign o_ctrl.idx  = r_idx;

endmodule

FILE: hw/rtl/boot_frame_builder_crc32_unit.sv
// ----------------------------------------------------------------------------
// Boot frame builder with CRC-32
// Buffers chunk bytes with a running CRC and emits start, stop and chunk frames.
// ----------------------------------------------------------------------------
// A chunk byte that does not close the chunk is stored and fed into the CRC; busy stays low.
// Start or stop frame: header CRC in HDR0, HDR1, then six beats, one per cycle.
// Chunk frame: header CRC in HDR0, HDR1, then ten plus byte-count beats.
// The header CRC steps through the one shared byte-wide CRC unit.
// Beats cannot be stalled. Synchronous active-low reset clears the sequencer
// and byte count; it presets the running CRC to ones, the commands to 1, 2, 3.
module boot_frame_builder_crc32_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_func,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    output logic       o_out_valid,
    output logic [7:0] o_out_byte,
    output logic       o_end_of_frame
);
    import bfb_pkg::*;

    logic [7:0]       r_start_cmd, r_end_cmd, r_chunk_cmd;
    logic [CNT_W-1:0] r_count;
    logic [31:0]      r_run_crc;
    logic [31:0]      r_hdr_crc;
    logic [7:0]       r_cmd;
    logic [7:0]       r_second;
    logic             r_chunk;

    t_seq_req         req;
    t_seq_ctrl        ctrl;
    logic             accept;
    logic             is_chunk;
    logic             close;
    logic [CNT_W:0]   count_inc;
    logic [31:0]      crc_in;
    logic [7:0]       crc_byte;
    logic [31:0]      crc_out;
    logic [31:0]      hdr_fin;
    logic [31:0]      run_fin;
    logic [7:0]       ram_rdata;
    logic [IDX_W-1:0] rd_off;

    assign accept    = start && !busy;
    assign is_chunk  = (i_func == FUNC_CHUNK);
    assign count_inc = {1'b0, r_count} + (CNT_W + 1)'(1);
    // The store fills up after this byte when the count reaches its depth.
    assign close     = is_chunk && (i_last_byte || (count_inc >= (CNT_W + 1)'(MAX_CHUNK)));

    assign req.go       = accept && ((i_func == FUNC_START) || (i_func == FUNC_STOP) || close);
    assign req.last_idx = is_chunk ? (IDX_W'(HDR_LEN - 1) + IDX_W'(count_inc))
                                   : IDX_W'(CTRL_LEN - 1);

    bfb_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_ctrl  (ctrl)
    );

    assign busy = ctrl.busy;

    always_comb begin
        priority if (ctrl.hdr0) begin
            crc_in   = CRC_ONES;
            crc_byte = r_cmd;
        end else if (ctrl.hdr1) begin
            crc_in   = r_hdr_crc;
            crc_byte = r_second;
        end else begin
            crc_in   = r_run_crc;
            crc_byte = i_data_byte;
        end
    end

    bfb_crc_unit u_crc (
        .i_crc  (crc_in),
        .i_byte (crc_byte),
        .o_crc  (crc_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_cmd <= 8'd1;
            r_end_cmd   <= 8'd2;
            r_chunk_cmd <= 8'd3;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_START_CMD: r_start_cmd <= i_cfg_data;
                REG_END_CMD:   r_end_cmd   <= i_cfg_data;
                REG_CHUNK_CMD: r_chunk_cmd <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_run_crc <= CRC_ONES;
        end else if (accept && is_chunk) begin
            r_count   <= count_inc[CNT_W-1:0];
            r_run_crc <= crc_out;
        end else if (ctrl.done && r_chunk) begin
            r_count   <= '0;
            r_run_crc <= CRC_ONES;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk <= 1'b0;
        end else if (req.go) begin
            r_chunk <= is_chunk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req.go) begin
            unique case (i_func)
                FUNC_START: r_cmd <= r_start_cmd;
                FUNC_STOP:  r_cmd <= r_end_cmd;
                default:    r_cmd <= r_chunk_cmd;
            endcase
            r_second <= is_chunk ? 8'({2'b00, 6'(count_inc)}) : 8'd0;
        end
        if (ctrl.hdr0 || ctrl.hdr1) begin
            r_hdr_crc <= crc_out;
        end
    end

    // The read address runs ahead of the payload beats, as the store registers its read data.
    assign rd_off = ctrl.idx - IDX_W'(HDR_LEN - 1);

    bfb_ram #(
        .WIDTH (8),
        .DEPTH (MAX_CHUNK)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (accept && is_chunk),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (i_data_byte),
        .i_raddr (rd_off[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign hdr_fin = ~r_hdr_crc;
    assign run_fin = ~r_run_crc;

    always_comb begin
        priority if (ctrl.idx == IDX_W'(0)) begin
            o_out_byte = r_cmd;
        end else if (ctrl.idx == IDX_W'(1)) begin
            o_out_byte = r_second;
        end else if (ctrl.idx == IDX_W'(2)) begin
            o_out_byte = hdr_fin[7:0];
        end else if (ctrl.idx == IDX_W'(3)) begin
            o_out_byte = hdr_fin[15:8];
        end else if (ctrl.idx == IDX_W'(4)) begin
            o_out_byte = hdr_fin[23:16];
        end else if (ctrl.idx == IDX_W'(5)) begin
            o_out_byte = hdr_fin[31:24];
        end else if (ctrl.idx == IDX_W'(6)) begin
            o_out_byte = run_fin[7:0];
        end else if (ctrl.idx == IDX_W'(7)) begin
            o_out_byte = run_fin[15:8];
        end else if (ctrl.idx == IDX_W'(8)) begin
            o_out_byte = run_fin[23:16];
        end else if (ctrl.idx == IDX_W'(9)) begin
            o_out_byte = run_fin[31:24];
        end else begin
            o_out_byte = ram_rdata;
        end
    end

    assign o_out_valid    = ctrl.emit;
    assign o_end_of_frame = ctrl.done;

endmodule

FILE: hw/rtl/bfb_checker.sv
// ----------------------------------------------------------------------------
// Boot frame builder checker
// Port-level checks on the beat strobe, frame end and busy, bound to the top.
// ----------------------------------------------------------------------------
module bfb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] i_func,
    input logic       o_out_valid,
    input logic       o_end_of_frame
);
    import bfb_pkg::*;

    a_eof_is_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_end_of_frame |-> o_out_valid)
        else $error("frame end flagged without a beat");

    a_beat_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> busy)
        else $error("beat while idle");

    a_gap_after_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_end_of_frame |=> !o_out_valid)
        else $error("beat right after frame end");

    a_idle_after_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> $past(o_end_of_frame))
        else $error("busy dropped before frame end");

    a_start_frame_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_func == FUNC_START || i_func == FUNC_STOP)) |=> busy)
        else $error("control frame request did not start a frame");

endmodule

bind boot_frame_builder_crc32_unit bfb_checker u_bfb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_func         (i_func),
    .o_out_valid    (o_out_valid),
    .o_end_of_frame (o_end_of_frame)
);

FILE: verif/boot_frame_builder_crc32_frame_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Boot frame builder frame checker
// Watches the request, register and link sides of the frame builder. It
// computes the bytes that each accepted request must send and compares every
// link beat with the oldest byte still owed.
// ----------------------------------------------------------------------------
module boot_frame_builder_crc32_frame_check (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_busy,
    input  logic [1:0] i_func,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_out_valid,
    input  logic [7:0] i_out_byte,
    input  logic       i_end_of_frame,
    input  logic       i_done,
    output int         o_error_count,
    output int         o_pending
);
    import bfb_pkg::*;

    typedef struct packed {
        logic [7:0] link_byte;
        logic       frame_end;
    } t_link_beat;

    t_link_beat  owed_beats[$];
    logic [7:0]  payload_buf [MAX_CHUNK];
    int          payload_count;
    logic [31:0] payload_crc;
    logic [7:0]  start_cmd;
    logic [7:0]  stop_cmd;
    logic [7:0]  chunk_cmd;
    logic        leftovers_checked;

    initial begin
        o_error_count = 0;
        o_pending     = 0;
    end

    task automatic flag_error(input string msg);
        if (o_error_count < 100) begin
            $display("ERROR at %0t ns: %s", $time, msg);
        end
        o_error_count++;
    endtask

    // Reflected CRC-32, one byte, least significant bit first.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
                                               input logic [7:0]  value);
        logic [31:0] acc;
        acc = crc ^ {24'h0, value};
        for (int k = 0; k < 8; k++) begin
            acc = (acc >> 1) ^ (acc[0] ? CRC_POLY : 32'h0);
        end
        return acc;
    endfunction

    task automatic owe_byte(input logic [7:0] value);
        t_link_beat beat;
        beat.link_byte = value;
        beat.frame_end = 1'b0;
        owed_beats.push_back(beat);
    endtask

    task automatic owe_crc_le(input logic [31:0] crc);
        for (int k = 0; k < 4; k++) begin
            owe_byte(crc[8*k +: 8]);
        end
    endtask

    // Command byte, second byte, then the inverted CRC of those two.
    task automatic owe_header(input logic [7:0] cmd, input logic [7:0] second);
        logic [31:0] crc;
        crc = crc32_byte(crc32_byte(CRC_ONES, cmd), second);
        owe_byte(cmd);
        owe_byte(second);
        owe_crc_le(~crc);
    endtask

    task automatic predict_request(input logic [1:0] func, input logic [7:0] data,
                                   input logic last);
        int         first;
        t_link_beat tail;
        first = owed_beats.size();
        case (func)
            FUNC_START: owe_header(start_cmd, 8'h00);
            FUNC_STOP:  owe_header(stop_cmd, 8'h00);
            FUNC_CHUNK: begin
                if (payload_count < MAX_CHUNK) begin
                    payload_buf[payload_count] = data;
                    payload_crc = crc32_byte(payload_crc, data);
                    payload_count++;
                end
                // A full buffer closes the chunk even without the last mark.
                if (last || payload_count >= MAX_CHUNK) begin
                    owe_header(chunk_cmd, 8'(payload_count & 6'h3F));
                    owe_crc_le(~payload_crc);
                    for (int k = 0; k < payload_count; k++) begin
                        owe_byte(payload_buf[k]);
                    end
                    payload_count = 0;
                    payload_crc   = CRC_ONES;
                end
            end
            default: ;
        endcase
        if (owed_beats.size() > first) begin
            tail = owed_beats.pop_back();
            tail.frame_end = 1'b1;
            owed_beats.push_back(tail);
        end
    endtask

    task automatic check_beat();
        t_link_beat want;
        if (owed_beats.size() == 0) begin
            flag_error($sformatf("unexpected beat byte=%02h eof=%0b",
                                 i_out_byte, i_end_of_frame));
        end else begin
            want = owed_beats.pop_front();
            if (i_out_byte !== want.link_byte) begin
                flag_error($sformatf("out_byte %02h, expected %02h",
                                     i_out_byte, want.link_byte));
            end
            if (i_end_of_frame !== want.frame_end) begin
                flag_error($sformatf("end_of_frame %0b, expected %0b (byte %02h)",
                                     i_end_of_frame, want.frame_end, want.link_byte));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            owed_beats.delete();
            payload_count     = 0;
            payload_crc       = CRC_ONES;
            start_cmd         = 8'd1;
            stop_cmd          = 8'd2;
            chunk_cmd         = 8'd3;
            leftovers_checked = 1'b0;
        end else begin
            if (i_out_valid) begin
                check_beat();
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_START_CMD: start_cmd = i_cfg_data;
                    REG_END_CMD:   stop_cmd  = i_cfg_data;
                    REG_CHUNK_CMD: chunk_cmd = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                predict_request(i_func, i_data_byte, i_last_byte);
            end
            if (i_done && !leftovers_checked) begin
                leftovers_checked = 1'b1;
                if (owed_beats.size() != 0) begin
                    flag_error($sformatf("%0d expected beats never arrived",
                                         owed_beats.size()));
                end
            end
        end
        o_pending <= owed_beats.size();
    end

endmodule

FILE: verif/boot_frame_builder_crc32_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Boot frame builder testbench
// Sends start, stop and chunk requests under several command settings and
// sender gap rates; the frame checker predicts and compares every beat.
// ----------------------------------------------------------------------------
module boot_frame_builder_crc32_unit_test;
    import bfb_pkg::*;

    localparam logic [1:0] FUNC_UNUSED    = 2'd3;
    localparam int         SETTLE_CYCLES  = 16;
    localparam int         WATCHDOG_LIMIT = 5000;
    localparam int         PHASE_ITEMS    = 100;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [1:0] i_func;
    logic [7:0] i_data_byte;
    logic       i_last_byte;
    logic       i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [7:0] i_cfg_data;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_end_of_frame;
    logic       tb_done;
    int         error_count;
    int         pending_beats;
    int         sender_idle_pct;
    int         quiet_cycles;

    boot_frame_builder_crc32_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out_valid),
        .o_out_byte     (o_out_byte),
        .o_end_of_frame (o_end_of_frame)
    );

    boot_frame_builder_crc32_frame_check frame_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_func         (i_func),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_out_valid    (o_out_valid),
        .i_out_byte     (o_out_byte),
        .i_end_of_frame (o_end_of_frame),
        .i_done         (tb_done),
        .o_error_count  (error_count),
        .o_pending      (pending_beats)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #10 i_clk = ~i_clk;

    // Watchdog: counts cycles with no request, beat or register write.
    initial begin
        quiet_cycles = 0;
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_out_valid || i_cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Holds start until the request is taken, then idles at random.
    task automatic send_request(input logic [1:0] func, input logic [7:0] data,
                                input logic last);
        i_func      <= func;
        i_data_byte <= data;
        i_last_byte <= last;
        start       <= 1'b1;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Waits until every owed beat has arrived and the block has gone quiet.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_beats != 0 || busy) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_commands(input logic [7:0] start_val, input logic [7:0] stop_val,
                                  input logic [7:0] chunk_val);
        logic [1:0] idx [3];
        logic [7:0] val [3];
        idx = '{REG_START_CMD, REG_END_CMD, REG_CHUNK_CMD};
        val = '{start_val, stop_val, chunk_val};
        drain();
        for (int k = 0; k < 3; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_random_phase(input int target);
        int         sent;
        int         len;
        int         kind;
        logic       full;
        logic       last;
        logic [1:0] func;
        sent = 0;
        while (sent < target) begin
            kind = $urandom_range(99);
            if (kind < 70) begin
                // Well-formed chunk; a full one may end without the last mark.
                full = ($urandom_range(99) < 18);
                if (full) begin
                    len = MAX_CHUNK;
                end else if ($urandom_range(1)) begin
                    len = $urandom_range(8, 1);
                end else begin
                    len = $urandom_range(MAX_CHUNK - 1, 1);
                end
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(99) < 4) begin
                        func = ($urandom_range(2) == 0) ? FUNC_UNUSED :
                               ($urandom_range(1) ? FUNC_START : FUNC_STOP);
                        send_request(func, 8'($urandom), 1'($urandom));
                        if (func != FUNC_UNUSED) begin
                            sent++;
                        end
                    end
                    last = (k == len - 1) ? (full ? 1'($urandom) : 1'b1) : 1'b0;
                    send_request(FUNC_CHUNK, 8'($urandom), last);
                    sent++;
                end
            end else if (kind < 85) begin
                send_request($urandom_range(1) ? FUNC_START : FUNC_STOP,
                             8'($urandom), 1'($urandom));
                sent++;
            end else if (kind < 93) begin
                send_request(FUNC_UNUSED, 8'($urandom), 1'($urandom));
            end else begin
                // Broken chunk: a few bytes left open for later requests.
                len = $urandom_range(3, 1);
                for (int k = 0; k < len; k++) begin
                    send_request(FUNC_CHUNK, 8'($urandom), 1'b0);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_func          <= FUNC_START;
        i_data_byte     <= 8'h00;
        i_last_byte     <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= REG_START_CMD;
        i_cfg_data      <= 8'h00;
        tb_done         <= 1'b0;
        sender_idle_pct = 29;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests under the reset command values.
        send_request(FUNC_START, 8'h00, 1'b0);
        send_request(FUNC_STOP, 8'hFF, 1'b1);
        send_request(FUNC_START, 8'hFF, 1'b1);
        send_request(FUNC_UNUSED, 8'hFF, 1'b1);
        send_request(FUNC_UNUSED, 8'h00, 1'b0);
        send_request(FUNC_CHUNK, 8'h00, 1'b1);
        send_request(FUNC_CHUNK, 8'hFF, 1'b1);
        send_request(FUNC_CHUNK, 8'h01, 1'b0);
        send_request(FUNC_START, 8'h3C, 1'b0);
        send_request(FUNC_CHUNK, 8'h80, 1'b0);
        send_request(FUNC_UNUSED, 8'h55, 1'b1);
        send_request(FUNC_STOP, 8'h00, 1'b0);
        send_request(FUNC_CHUNK, 8'h7F, 1'b1);
        send_request(FUNC_CHUNK, 8'hAA, 1'b0);
        send_request(FUNC_CHUNK, 8'h55, 1'b0);
        send_request(FUNC_CHUNK, 8'hC3, 1'b1);

        write_commands(8'h00, 8'hFF, 8'h00);
        run_random_phase(PHASE_ITEMS);

        sender_idle_pct = 68;
        write_commands(8'hFF, 8'h00, 8'hFF);
        run_random_phase(PHASE_ITEMS);

        sender_idle_pct = 0;
        write_commands(8'($urandom), 8'($urandom), 8'($urandom));
        run_random_phase(PHASE_ITEMS);

        drain();
        tb_done <= 1'b1;
        repeat (2) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: boot_frame_builder_crc32_unit.f
hw/rtl/bfb_pkg.sv
hw/rtl/bfb_ram.sv
hw/rtl/bfb_crc_unit.sv
hw/rtl/bfb_seq.sv
hw/rtl/boot_frame_builder_crc32_unit.sv
hw/rtl/bfb_checker.sv
verif/boot_frame_builder_crc32_frame_check.sv
verif/boot_frame_builder_crc32_unit_test.sv
